>>> hdl/assert_macros.svh
// Assertion helpers for the RTL files, included by lfsr_keystream_byte_decryptor.sv.
// Both macros sample on the rising edge of clk and stay quiet while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a condition that holds at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Checks that a condition implies a consequence in the next cycle.
`define ASSERT_NEXT(label, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/lkd_pkg.sv
`timescale 1ns / 1ps

package lkd_pkg;

  localparam int unsigned KeyWidth  = 16;
  localparam int unsigned ByteWidth = 8;

  // Feedback taps of the Fibonacci LFSR.
  localparam int unsigned TapA = 6;
  localparam int unsigned TapB = 9;
  localparam int unsigned TapC = 13;
  localparam int unsigned TapTop = 15;

  localparam logic [KeyWidth-1:0] LowMask  = 16'h00FF;
  localparam logic [KeyWidth-1:0] HighMask = 16'hFF00;

  // One decrypted result as it moves from the keystream unit to the output buffer.
  typedef struct packed {
    logic [ByteWidth-1:0] plain_byte;
    logic                 last_out;
  } lkd_result_t;

  // One right shift of the LFSR with bit 0 ^ 6 ^ 9 ^ 13 fed into the top bit.
  function automatic logic [KeyWidth-1:0] lfsr_advance(input logic [KeyWidth-1:0] s);
    logic fb;
    fb = s[0] ^ s[TapA] ^ s[TapB] ^ s[TapC];
    lfsr_advance = {fb, s[TapTop:1]};
  endfunction

endpackage

>>> hdl/lkd_keystream.sv
`timescale 1ns / 1ps

module lkd_keystream import lkd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 key_write,
  input  logic [KeyWidth-1:0]  key_value,
  input  logic                 accept,
  input  logic [ByteWidth-1:0] cipher_byte,
  input  logic                 last_byte,
  output lkd_result_t          result
);

  logic [KeyWidth-1:0] cipher_key;
  logic [KeyWidth-1:0] lfsr_state;
  logic                high_half;
  logic [KeyWidth-1:0] lfsr_next;
  logic [KeyWidth-1:0] masked;
  logic [ByteWidth-1:0] ks_byte;

  // Pick the keystream byte for the current message position, XOR it in and form the next LFSR state.
  always_comb begin
    if (high_half) begin
      masked  = (lfsr_state & HighMask) >> ByteWidth;
      lfsr_next = lfsr_advance(lfsr_state);
    end else begin
      masked  = lfsr_state & LowMask;
      lfsr_next = lfsr_state;
    end
    ks_byte = masked[ByteWidth-1:0];
    result.plain_byte = cipher_byte ^ ks_byte;
    result.last_out   = last_byte;
  end

  // Key register and LFSR state; a key write or a last byte re-seeds the stream.
  always_ff @(posedge clk) begin
    if (rst) begin
      cipher_key <= '0;
      lfsr_state <= lfsr_advance('0);
      high_half  <= 1'b0;
    end else if (key_write) begin
      cipher_key <= key_value;
      lfsr_state <= lfsr_advance(key_value);
      high_half  <= 1'b0;
    end else if (accept) begin
      if (last_byte) begin
        lfsr_state <= lfsr_advance(cipher_key);
        high_half  <= 1'b0;
      end else begin
        lfsr_state <= lfsr_next;
        high_half  <= ~high_half;
      end
    end
  end

endmodule

>>> hdl/lfsr_keystream_byte_decryptor.sv
`timescale 1ns / 1ps

// Decrypts a byte stream with a 16-bit LFSR keystream: every accepted cipher byte
// gives one plain byte in the output register, or in the skid entry behind it, and a
// new byte can be taken in every cycle while in_stall is low. The keystream update and
// the XOR sit between the input port and the output register; a one-entry skid stage
// behind the output register lets one more byte in while a result is stalled, so
// in_stall is registered. Writing cipher_key (cfg_ready is always high) re-seeds
// the LFSR at once; write it only while no bytes are in flight. A byte with last_byte
// set ends the message and the next byte starts again from the key stepped once.
module lfsr_keystream_byte_decryptor import lkd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [KeyWidth-1:0]  cipher_key,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [ByteWidth-1:0] cipher_byte,
  input  logic                 last_byte,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ByteWidth-1:0] plain_byte,
  output logic                 last_out
);

  `include "assert_macros.svh"

  logic        accept;
  logic        take;
  logic        skid_valid;
  lkd_result_t new_result;
  lkd_result_t out_reg;
  lkd_result_t skid_reg;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid;
  assign accept    = in_valid & ~skid_valid;
  assign take      = out_valid & ~out_stall;

  lkd_keystream u_keystream (
    .clk         (clk),
    .rst         (rst),
    .key_write   (cfg_valid),
    .key_value   (cipher_key),
    .accept      (accept),
    .cipher_byte (cipher_byte),
    .last_byte   (last_byte),
    .result      (new_result)
  );

  // Output register with a skid entry behind it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (take) begin
        skid_valid <= 1'b0;
      end
    end else if (accept) begin
      if (take || !out_valid) begin
        out_valid <= 1'b1;
      end else begin
        skid_valid <= 1'b1;
      end
    end else if (take) begin
      out_valid <= 1'b0;
    end
  end

  // Payload moves without reset.
  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (take) begin
        out_reg <= skid_reg;
      end
    end else if (accept) begin
      if (take || !out_valid) begin
        out_reg <= new_result;
      end else begin
        skid_reg <= new_result;
      end
    end
  end

  assign plain_byte = out_reg.plain_byte;
  assign last_out   = out_reg.last_out;

  // The skid entry is used only behind a full output register.
  `ASSERT_CLK(a_skid_behind_out, !skid_valid || out_valid, "skid entry without output")
  // A transfer into a stalled full output register lands in the skid entry.
  `ASSERT_NEXT(a_skid_fill, accept && out_valid && out_stall, skid_valid,
               "accepted byte lost behind stalled output")
  // A transfer out while the skid entry is full refills the output from it.
  `ASSERT_NEXT(a_skid_drain, skid_valid && take, out_valid && !skid_valid,
               "skid entry not drained")

endmodule
